FILE: src/glos_pkg.sv
`timescale 1ns / 1ps

package glos_pkg;

   localparam int unsigned COORD_W = 8;
   localparam int unsigned WIDTH_W = 9;
   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned CELL_W  = 8;
   localparam int unsigned IDX_W   = 17;
   localparam int unsigned ERR_W   = 11;
   localparam int unsigned REQ_W   = 56;
   localparam int unsigned RSP_W   = 8;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 9'd256;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WALK = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_POST = 4'b1000
   } state_type;

endpackage

FILE: src/grid_line_of_sight_check_top.sv
`timescale 1ns / 1ps

// Line-of-sight checker over an occupancy grid of GRID_SIDE x GRID_SIDE signed
// byte cells held in one synchronous memory. A write request (tuser 0) stores
// one cell at a flat address; addresses beyond the grid are dropped. A query
// request (tuser 1) walks the Bresenham line from start to end, both included,
// reading one cell per cycle from the grid memory, and returns line_clear = 1
// only if every cell holds zero. A query ends early at the first nonzero or
// off-grid cell. The grid is not cleared at reset and must be loaded before it
// is queried. grid_width, the row stride, resets to 256; the user must write it
// through csr_we only while no request is in flight, as the block itself does
// not enforce this.
module grid_line_of_sight_check_top #(
   parameter int unsigned GRID_SIDE = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // cell_address, cell_value, start_x, start_y, end_x, end_y
   input  logic [glos_pkg::REQ_W-1:0]  req_tdata,
   // action
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // line_clear, zero padded
   output logic [glos_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_we,
   input  logic [glos_pkg::WIDTH_W-1:0] csr_wdata
);

   localparam int unsigned CELLS = GRID_SIDE * GRID_SIDE;
   localparam int unsigned AW    = $clog2(CELLS);
   localparam logic [31:0] CELLS_VAL = 32'(CELLS);

   logic [glos_pkg::CELL_W-1:0] grid_mem [CELLS];

   glos_pkg::state_type state_ff, state_in;

   logic [glos_pkg::WIDTH_W-1:0] width_ff;
   logic [glos_pkg::COORD_W-1:0] x_ff, x_in, y_ff, y_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [glos_pkg::COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic                         sx_ff, sx_in, sy_ff, sy_in;
   logic signed [glos_pkg::ERR_W-1:0] err_ff, err_in;

   logic                         rd_valid_ff, rd_valid_in;
   logic                         rd_inrange_ff, rd_inrange_in;
   logic                         rd_last_ff, rd_last_in;
   logic [glos_pkg::CELL_W-1:0]  rd_data_ff;
   logic                         result_ff, result_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic                         rsp_data_ff, rsp_data_in;

   logic                         req_accept;
   logic                         wr_en;
   logic [glos_pkg::ADDR_W-1:0]  wr_addr;
   logic [glos_pkg::CELL_W-1:0]  wr_value;
   logic [glos_pkg::COORD_W-1:0] q_sx, q_sy, q_ex, q_ey;
   logic [glos_pkg::COORD_W-1:0] q_dx, q_dy;
   logic [glos_pkg::IDX_W-1:0]   idx;
   logic                         idx_ok;
   logic                         at_end;
   logic signed [glos_pkg::ERR_W:0] e2;
   logic                         step_x, step_y;
   logic                         blocked, finish;

   assign req_tready = (state_ff == glos_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign wr_addr  = req_tdata[15:0];
   assign wr_value = req_tdata[23:16];
   assign q_sx     = req_tdata[31:24];
   assign q_sy     = req_tdata[39:32];
   assign q_ex     = req_tdata[47:40];
   assign q_ey     = req_tdata[55:48];
   assign q_dx     = (q_ex > q_sx) ? (q_ex - q_sx) : (q_sx - q_ex);
   assign q_dy     = (q_ey > q_sy) ? (q_ey - q_sy) : (q_sy - q_ey);

   assign wr_en = req_accept && (req_tuser == glos_pkg::ACT_WRITE)
                  && ({16'd0, wr_addr} < CELLS_VAL);

   assign idx    = ({9'd0, y_ff} * {8'd0, width_ff}) + {9'd0, x_ff};
   assign idx_ok = ({15'd0, idx} < CELLS_VAL);
   assign at_end = (x_ff == ex_ff) && (y_ff == ey_ff);

   assign e2     = {err_ff, 1'b0};
   assign step_x = e2 > -$signed({4'd0, dy_ff});
   assign step_y = e2 < $signed({4'd0, dx_ff});

   assign blocked = !rd_inrange_ff || (rd_data_ff != '0);
   assign finish  = rd_valid_ff && (blocked || rd_last_ff);

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      err_in        = err_ff;
      rd_valid_in   = 1'b0;
      rd_inrange_in = idx_ok;
      rd_last_in    = at_end;
      result_in     = result_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         glos_pkg::ST_IDLE: begin
            if (req_accept && (req_tuser == glos_pkg::ACT_QUERY)) begin
               x_in     = q_sx;
               y_in     = q_sy;
               ex_in    = q_ex;
               ey_in    = q_ey;
               dx_in    = q_dx;
               dy_in    = q_dy;
               sx_in    = q_sx < q_ex;
               sy_in    = q_sy < q_ey;
               err_in   = $signed({3'd0, q_dx}) - $signed({3'd0, q_dy});
               state_in = glos_pkg::ST_WALK;
            end
         end
         glos_pkg::ST_WALK: begin
            rd_valid_in = 1'b1;
            if (step_x) begin
               x_in = sx_ff ? x_ff + 8'd1 : x_ff - 8'd1;
            end
            if (step_y) begin
               y_in = sy_ff ? y_ff + 8'd1 : y_ff - 8'd1;
            end
            err_in = err_ff - (step_x ? $signed({3'd0, dy_ff}) : '0)
                            + (step_y ? $signed({3'd0, dx_ff}) : '0);
            if (finish) begin
               rd_valid_in = 1'b0;
               result_in   = !blocked;
               state_in    = glos_pkg::ST_POST;
            end else if (at_end) begin
               state_in = glos_pkg::ST_WAIT;
            end
         end
         glos_pkg::ST_WAIT: begin
            if (finish) begin
               result_in = !blocked;
               state_in  = glos_pkg::ST_POST;
            end
         end
         glos_pkg::ST_POST: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = result_ff;
               state_in      = glos_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = glos_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= glos_pkg::ST_IDLE;
         width_ff      <= glos_pkg::WIDTH_RESET;
         rd_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            width_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      ex_ff         <= ex_in;
      ey_ff         <= ey_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      err_ff        <= err_in;
      rd_inrange_ff <= rd_inrange_in;
      rd_last_ff    <= rd_last_in;
      result_ff     <= result_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // grid memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[AW'(wr_addr)] <= wr_value;
      end
      if (state_ff == glos_pkg::ST_WALK) begin
         rd_data_ff <= grid_mem[AW'(idx)];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

endmodule

FILE: test/grid_line_of_sight_check_checker.sv
`timescale 1ns / 1ps

module grid_line_of_sight_check_checker #(
   parameter int unsigned GRID_CELLS = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [glos_pkg::REQ_W-1:0]    req_tdata,
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [glos_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_we,
   input  logic [glos_pkg::WIDTH_W-1:0]  csr_wdata,
   output int                            errors,
   output int                            pending
);

   logic [glos_pkg::CELL_W-1:0]  occupancy [GRID_CELLS];
   logic [glos_pkg::WIDTH_W-1:0] row_stride;
   bit                           clear_expected [$];

   initial begin
      errors = 0;
      pending = 0;
      row_stride = glos_pkg::WIDTH_RESET;
      foreach (occupancy[i]) occupancy[i] = '0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
   endtask

   // walks the line and stops at the first blocked or off-grid cell
   function automatic bit predict_clear(input int x0, input int y0, input int x1,
                                        input int y1);
      int x, y, dx, dy, sx, sy, err, e2;
      int unsigned idx;
      bit clear, done;
      x = x0;
      y = y0;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      clear = 1'b1;
      done = 1'b0;
      while (!done) begin
         idx = int'(y) * int'(row_stride) + int'(x);
         if (idx >= GRID_CELLS) begin
            clear = 1'b0;
            done = 1'b1;
         end else if (occupancy[idx] != '0) begin
            clear = 1'b0;
            done = 1'b1;
         end else if (x == x1 && y == y1) begin
            done = 1'b1;
         end else begin
            e2 = 2 * err;
            if (e2 > -dy) begin
               err -= dy;
               x += sx;
            end
            if (e2 < dx) begin
               err += dx;
               y += sy;
            end
         end
      end
      return clear;
   endfunction

   always @(posedge clock) begin : monitor
      logic [glos_pkg::ADDR_W-1:0] addr;
      bit                          want;
      if (reset) begin
         row_stride = glos_pkg::WIDTH_RESET;
         clear_expected.delete();
      end else begin
         if (csr_we) row_stride = csr_wdata;
         if (req_tvalid && req_tready) begin
            if (req_tuser == glos_pkg::ACT_WRITE) begin
               addr = req_tdata[15:0];
               if (addr < GRID_CELLS) occupancy[addr] = req_tdata[23:16];
            end else begin
               want = predict_clear(int'(req_tdata[31:24]), int'(req_tdata[39:32]),
                                    int'(req_tdata[47:40]), int'(req_tdata[55:48]));
               clear_expected.insert(clear_expected.size(), want);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (clear_expected.size() == 0) begin
               report_mismatch($sformatf("response 0x%02h with no query waiting", rsp_tdata));
            end else begin
               want = clear_expected.pop_front();
               if (rsp_tdata !== {{(glos_pkg::RSP_W-1){1'b0}}, want})
                  report_mismatch($sformatf("line_clear: got 0x%02h, want %0d",
                                            rsp_tdata, want));
            end
         end
      end
      pending <= clear_expected.size();
   end

endmodule

FILE: test/grid_line_of_sight_check_top_tb.sv
`timescale 1ns / 1ps

module grid_line_of_sight_check_top_tb;

   localparam int unsigned GRID_SIDE    = 256;
   localparam int unsigned GRID_CELLS   = GRID_SIDE * GRID_SIDE;
   localparam int          RANDOM_ITEMS = 1930;
   localparam int          PHASES       = 9;

   typedef enum int {
      ZERO_FILL,
      RANDOM_FILL,
      PAVE_CLEAR,
      PAVE_BLOCKED
   } fill_mode_type;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [glos_pkg::REQ_W-1:0]   req_tdata;
   logic                         req_tuser;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [glos_pkg::RSP_W-1:0]   rsp_tdata;
   logic                         csr_we;
   logic [glos_pkg::WIDTH_W-1:0] csr_wdata;
   int                           errors;
   int                           pending;

   bit                 cell_loaded [GRID_CELLS];
   int unsigned        row_stride_now;
   int                 items_sent;
   bit                 steady;
   bit                 hold_rsp;
   bit                 hold_done;

   grid_line_of_sight_check_top #(
      .GRID_SIDE (GRID_SIDE)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   grid_line_of_sight_check_checker #(
      .GRID_CELLS (GRID_CELLS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial begin
      #6_000_000;
      $display("Some tests failed");
      $finish;
   end

   // response side, with one long hold-off to back the block up
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= !reset && (steady || $urandom_range(99) >= 26);
      end
   end

   task automatic send_item(input logic act, input logic [glos_pkg::REQ_W-1:0] data);
      while (!steady && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_cell(input logic [glos_pkg::ADDR_W-1:0] addr,
                             input logic [glos_pkg::CELL_W-1:0] val);
      send_item(glos_pkg::ACT_WRITE, {$urandom(), val, addr});
      cell_loaded[addr] = 1'b1;
   endtask

   function automatic logic [glos_pkg::CELL_W-1:0] pick_obstacle();
      case ($urandom_range(3))
         0: return 8'hFF;
         1: return 8'h80;
         2: return 8'h7F;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic logic [glos_pkg::CELL_W-1:0] pick_value();
      return ($urandom_range(99) < 80) ? 8'h00 : pick_obstacle();
   endfunction

   // every in-grid flat index along the whole line, each once
   function automatic void trace_line(input int x0, input int y0, input int x1, input int y1,
                                      output int unsigned cells[$]);
      int x, y, dx, dy, sx, sy, err, e2;
      int unsigned idx;
      bit seen [int unsigned];
      bit done;
      cells.delete();
      x = x0;
      y = y0;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      done = 1'b0;
      while (!done) begin
         idx = y * row_stride_now + x;
         if (idx < GRID_CELLS && !seen.exists(idx)) begin
            seen[idx] = 1'b1;
            cells.insert(cells.size(), idx);
         end
         if (x == x1 && y == y1) begin
            done = 1'b1;
         end else begin
            e2 = 2 * err;
            if (e2 > -dy) begin
               err -= dy;
               x += sx;
            end
            if (e2 < dx) begin
               err += dx;
               y += sy;
            end
         end
      end
   endfunction

   // loads the cells on the line as the mode says, then asks the query
   task automatic run_query(input int x0, input int y0, input int x1, input int y1,
                            input fill_mode_type mode);
      int unsigned cells[$];
      int blocker;
      trace_line(x0, y0, x1, y1, cells);
      blocker = (cells.size() > 0) ? $urandom_range(cells.size() - 1) : 0;
      foreach (cells[i]) begin
         case (mode)
            ZERO_FILL: if (!cell_loaded[cells[i]]) write_cell(16'(cells[i]), 8'h00);
            RANDOM_FILL: if (!cell_loaded[cells[i]]) write_cell(16'(cells[i]), pick_value());
            PAVE_CLEAR: write_cell(16'(cells[i]), 8'h00);
            PAVE_BLOCKED: write_cell(16'(cells[i]), (i == blocker) ? pick_obstacle() : 8'h00);
            default: ;
         endcase
      end
      send_item(glos_pkg::ACT_QUERY, {8'(y1), 8'(x1), 8'(y0), 8'(x0), 24'($urandom())});
   endtask

   task automatic program_row_stride(input int unsigned stride);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= 9'(stride);
      @(posedge clock);
      csr_we <= 1'b0;
      row_stride_now = stride;
   endtask

   function automatic int near(input int c, input int span);
      int v;
      v = c + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
   endfunction

   initial begin
      int unsigned   stride_plan [PHASES];
      int            random_base;
      int            phase_end;
      int            pick;
      int            span;
      int            bx, by;
      int            x0, y0, x1, y1;
      fill_mode_type mode;

      stride_plan = '{256, 1, 511, 0, 97, 255, 257, 2, 256};
      items_sent = 0;
      steady = 1'b0;
      hold_rsp = 1'b0;
      hold_done = 1'b0;
      row_stride_now = 32'(glos_pkg::WIDTH_RESET);
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= glos_pkg::ACT_WRITE;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners, value extremes and unknown cells at the reset stride
      write_cell(16'h0000, 8'h80);
      write_cell(16'hFFFF, 8'h7F);
      write_cell(16'h0001, 8'hFF);
      write_cell(16'h0002, 8'h00);
      run_query(0, 0, 0, 0, ZERO_FILL);
      run_query(255, 255, 255, 255, ZERO_FILL);
      write_cell(16'h0000, 8'h00);
      run_query(0, 0, 0, 0, ZERO_FILL);
      run_query(0, 0, 2, 0, ZERO_FILL);
      run_query(2, 0, 0, 0, ZERO_FILL);
      // line running off the end of the grid
      program_row_stride(511);
      run_query(255, 255, 255, 255, ZERO_FILL);
      run_query(3, 127, 3, 129, ZERO_FILL);
      // zero stride folds every row onto the first
      program_row_stride(0);
      run_query(7, 0, 7, 255, ZERO_FILL);
      // column past the row width spills into the next row
      program_row_stride(10);
      run_query(12, 0, 14, 1, ZERO_FILL);

      random_base = items_sent;
      for (int p = 0; p < PHASES; p++) begin
         program_row_stride((p == 7) ? $urandom_range(2, 510) : stride_plan[p]);
         phase_end = random_base + (p + 1) * RANDOM_ITEMS / PHASES;
         while (items_sent < phase_end) begin
            if (items_sent - random_base >= 600) hold_rsp = 1'b1;
            steady = (items_sent - random_base >= 1100) && (items_sent - random_base < 1400);
            pick = $urandom_range(99);
            if (pick < 10) begin
               write_cell(16'($urandom()), 8'($urandom()));
            end else begin
               pick = $urandom_range(99);
               if (pick < 2) begin
                  x0 = $urandom_range(255);
                  y0 = $urandom_range(255);
                  x1 = $urandom_range(255);
                  y1 = $urandom_range(255);
               end else begin
                  span = (pick < 14) ? 40 : 8;
                  bx = $urandom_range(255);
                  by = $urandom_range(255);
                  x0 = near(bx, span);
                  y0 = near(by, span);
                  x1 = near(bx, span);
                  y1 = near(by, span);
               end
               pick = $urandom_range(99);
               if (pick < 30) mode = PAVE_CLEAR;
               else if (pick < 50) mode = PAVE_BLOCKED;
               else mode = RANDOM_FILL;
               run_query(x0, y0, x1, y1, mode);
            end
         end
      end
      steady = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/glos_pkg.sv
src/grid_line_of_sight_check_top.sv
test/grid_line_of_sight_check_checker.sv
test/grid_line_of_sight_check_top_tb.sv
